[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file of this block.
// Both macros sample on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked only while reset is low.
`define VCL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Property checked during reset as well.
`define VCL_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`endif

[hw/rtl/vcl_pkg.sv]
`default_nettype none
package vcl_pkg;
   localparam int BONE_COUNT      = 128;
   localparam int DYN_LIGHT_COUNT = 8;

   localparam int BONE_W     = 7;
   localparam int SLOT_W     = 3;
   localparam int BONE_DEPTH = (BONE_COUNT < (1 << BONE_W)) ? BONE_COUNT : (1 << BONE_W);
   localparam int DYN_SLOTS  =
      (DYN_LIGHT_COUNT < (1 << SLOT_W)) ? DYN_LIGHT_COUNT : (1 << SLOT_W);
   localparam int DV_DEPTH   = DYN_SLOTS * BONE_DEPTH;
   localparam int DV_AW      = BONE_W + SLOT_W;
   localparam int LCNT_W     = 4;

   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   localparam int ACC_W  = 36;
   localparam int NUM_W  = 37;
   localparam int ILL_W  = 26;
   localparam int MUL_AW = 35;
   localparam int MUL_BW = 24;
   localparam int PROD_W = 59;
   localparam int DIV_NW = 40;
   localparam int DIV_DW = 26;
   localparam int QUO_W  = 15;

   localparam logic signed [ACC_W-1:0]  ONE_Q28   = 36'sd268435456;
   localparam logic signed [PROD_W-1:0] Q28_BIAS  = 59'sd268435455;
   localparam logic [14:0]              ONE_Q14   = 15'd16384;
   localparam logic [15:0]              WRAP_MIN  = 16'd4096;
   // ceil(2^24 / 5): exact division by five for values below 2^22.
   localparam logic [MUL_BW-1:0]        RECIP5    = 24'd3355444;

   typedef enum logic [1:0] {
      ACT_SHADE     = 2'd0,
      ACT_LOAD_BONE = 2'd1,
      ACT_LOAD_DVEC = 2'd2,
      ACT_LOAD_DCOL = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      OP_FLAT = 3'd0,
      OP_WRAP = 3'd1,
      OP_BONE = 3'd2,
      OP_DVEC = 3'd3,
      OP_DCOL = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CSR_AMB_R  = 3'd0,
      CSR_AMB_G  = 3'd1,
      CSR_AMB_B  = 3'd2,
      CSR_DIR_R  = 3'd3,
      CSR_DIR_G  = 3'd4,
      CSR_DIR_B  = 3'd5,
      CSR_WRAP   = 3'd6,
      CSR_LIGHTS = 3'd7
   } csr_type;

   typedef struct packed {
      op_type              op;
      logic [BONE_W-1:0]   bone;
      logic [SLOT_W-1:0]   slot;
      logic                bone_ok;
      logic [2:0][15:0]    vec;
   } item_type;

   typedef struct packed {
      logic [2:0][15:0] ambient;
      logic [2:0][15:0] direct;
      logic [15:0]      wrap;
      logic [3:0]       lights;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;
endpackage
`default_nettype wire

[hw/rtl/vcl_front.sv]
`default_nettype none
module vcl_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_action,
   input  logic [6:0]             req_bone,
   input  logic [2:0]             req_light_slot,
   input  logic                   req_flat_shade,
   input  logic signed [15:0]     req_vec_x,
   input  logic signed [15:0]     req_vec_y,
   input  logic signed [15:0]     req_vec_z,
   input  vcl_pkg::q_status_type  q_status,
   output logic                   push,
   output vcl_pkg::item_type      push_item
);
   import vcl_pkg::*;

   logic     stage_valid_ff, stage_valid_in;
   item_type stage_ff, stage_in;
   logic     accept, keep, bone_ok, slot_ok;

   assign busy      = stage_valid_ff & q_status.full;
   assign push      = stage_valid_ff & ~q_status.full;
   assign push_item = stage_ff;
   assign accept    = start & ~busy;

   always_comb begin
      bone_ok        = 32'(req_bone) < BONE_COUNT;
      slot_ok        = 32'(req_light_slot) < DYN_LIGHT_COUNT;
      stage_in       = stage_ff;
      stage_in.bone  = req_bone;
      stage_in.slot  = req_light_slot;
      stage_in.bone_ok = bone_ok;
      stage_in.vec   = {req_vec_z, req_vec_y, req_vec_x};
      keep           = 1'b0;
      unique case (action_type'(req_action))
         ACT_SHADE: begin
            stage_in.op = req_flat_shade ? OP_FLAT : OP_WRAP;
            keep        = 1'b1;
         end
         ACT_LOAD_BONE: begin
            stage_in.op = OP_BONE;
            keep        = bone_ok;
         end
         ACT_LOAD_DVEC: begin
            stage_in.op = OP_DVEC;
            keep        = bone_ok & slot_ok;
         end
         ACT_LOAD_DCOL: begin
            stage_in.op = OP_DCOL;
            keep        = slot_ok;
         end
         default: keep = 1'b0;
      endcase
      // Loads that would be ignored are dropped here.
      stage_valid_in = (stage_valid_ff & ~push) | (accept & keep);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept && keep) begin
         stage_ff <= stage_in;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/vcl_queue.sv]
`default_nettype none
module vcl_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  vcl_pkg::item_type      push_item,
   input  logic                   pop,
   output vcl_pkg::item_type      pop_item,
   output vcl_pkg::q_status_type  status
);
   import vcl_pkg::*;

   item_type         entry_ff [QDEPTH];
   logic [QAW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QAW:0]     count_ff, count_in;

   assign status.full  = count_ff == (QAW + 1)'(QDEPTH);
   assign status.empty = count_ff == '0;
   assign pop_item     = entry_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QAW + 1)'(push) - (QAW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/vcl_div.sv]
`default_nettype none
module vcl_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vcl_pkg::DIV_NW-1:0]  dividend,
   input  logic [vcl_pkg::DIV_DW-1:0]  divisor,
   output logic                        done,
   output logic [vcl_pkg::QUO_W-1:0]   quotient
);
   import vcl_pkg::*;

   // Restoring division, one quotient bit per cycle. The caller guarantees
   // that the quotient fits in QUO_W bits.
   logic [DIV_NW-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              run_ff, run_in, done_ff, done_in;
   logic              ge;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      ge      = rem_ff >= dsh_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend;
         dsh_in = DIV_NW'(divisor) << (QUO_W - 1);
         quo_in = '0;
         cnt_in = 4'(QUO_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[QUO_W-2:0], ge};
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

[hw/rtl/vcl_back.sv]
`default_nettype none
module vcl_back (
   input  logic                   clock,
   input  logic                   reset,
   input  vcl_pkg::cfg_type       cfg,
   input  vcl_pkg::q_status_type  q_status,
   input  vcl_pkg::item_type      q_item,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic [14:0]            rsp_red,
   output logic [14:0]            rsp_green,
   output logic [14:0]            rsp_blue
);
   import vcl_pkg::*;

   typedef enum logic [19:0] {
      S_IDLE   = 20'h00001,
      S_FETCH  = 20'h00002,
      S_DOTM   = 20'h00004,
      S_DOTA   = 20'h00008,
      S_WRAP   = 20'h00010,
      S_DIVW   = 20'h00020,
      S_BASEM  = 20'h00040,
      S_BASEA  = 20'h00080,
      S_LFETCH = 20'h00100,
      S_LDOTM  = 20'h00200,
      S_LDOTA  = 20'h00400,
      S_LCHK   = 20'h00800,
      S_LCOLM  = 20'h01000,
      S_LCOLA  = 20'h02000,
      S_FLATM  = 20'h04000,
      S_FLATA  = 20'h08000,
      S_MAX    = 20'h10000,
      S_NSTART = 20'h20000,
      S_NWAIT  = 20'h40000,
      S_DONE   = 20'h80000
   } state_type;

   state_type                 state_ff, state_in;
   item_type                  item_ff, item_in;
   logic [1:0]                k_ff, k_in;
   logic [LCNT_W-1:0]         lcnt_ff, lcnt_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [QUO_W-1:0]          cw_ff, cw_in;
   logic [ILL_W-1:0]          mx_ff, mx_in;
   logic [2:0][ILL_W-1:0]     illum_ff, illum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0][14:0]          rsp_ff, rsp_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   // Tables: bone and dynamic vectors in memories, colors in registers.
   logic [2:0][15:0] bone_mem [BONE_DEPTH];
   logic [2:0][15:0] dv_mem [DV_DEPTH];
   logic [2:0][15:0] dcol_ff [DYN_SLOTS];
   logic [2:0][15:0] bone_rd_ff, dv_rd_ff;
   logic [DV_AW-1:0] dv_wr_addr, dv_rd_addr;

   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic signed [15:0]       vec_k, bl_k, dv_k, col_k;
   logic [15:0]              amb_k, dir_k, r_eff;
   logic signed [ACC_W-1:0]  c_cap, lc;
   logic signed [NUM_W-1:0]  num;
   logic                     num_pos;
   logic signed [ILL_W-1:0]  ill_k, base, dyn_term;
   logic signed [PROD_W-1:0] prod_adj;
   logic [2:0][ILL_W-1:0]    cl;
   logic [ILL_W-1:0]         mx01, mx;
   logic [LCNT_W-1:0]        nlights, lcnt_next;
   logic                     div_start, div_done;
   logic [DIV_NW-1:0]        div_dividend;
   logic [DIV_DW-1:0]        div_divisor;
   logic [QUO_W-1:0]         div_q;

   vcl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_ff[0];
   assign rsp_green = rsp_ff[1];
   assign rsp_blue  = rsp_ff[2];

   assign dv_wr_addr = DV_AW'(q_item.slot) * DV_AW'(BONE_DEPTH) + DV_AW'(q_item.bone);
   assign dv_rd_addr = DV_AW'(lcnt_ff[SLOT_W-1:0]) * DV_AW'(BONE_DEPTH) + DV_AW'(item_ff.bone);

   always_ff @(posedge clock) begin
      if (pop && q_item.op == OP_BONE) begin
         bone_mem[q_item.bone] <= q_item.vec;
      end
      bone_rd_ff <= bone_mem[item_ff.bone];
   end

   always_ff @(posedge clock) begin
      if (pop && q_item.op == OP_DVEC) begin
         dv_mem[dv_wr_addr] <= q_item.vec;
      end
      dv_rd_ff <= dv_mem[dv_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pop && q_item.op == OP_DCOL) begin
         dcol_ff[q_item.slot] <= q_item.vec;
      end
   end

   // Operand selection and derived values.
   always_comb begin
      vec_k    = $signed(item_ff.vec[k_ff]);
      bl_k     = item_ff.bone_ok ? $signed(bone_rd_ff[k_ff]) : 16'sd0;
      dv_k     = item_ff.bone_ok ? $signed(dv_rd_ff[k_ff]) : 16'sd0;
      col_k    = $signed(dcol_ff[lcnt_ff[SLOT_W-1:0]][k_ff]);
      amb_k    = cfg.ambient[k_ff];
      dir_k    = cfg.direct[k_ff];
      ill_k    = $signed(illum_ff[k_ff]);
      lc       = -acc_ff;
      c_cap    = (acc_ff > ONE_Q28) ? ONE_Q28 : acc_ff;
      r_eff    = (cfg.wrap < WRAP_MIN) ? WRAP_MIN : cfg.wrap;
      num      = $signed(NUM_W'(c_cap)) + $signed(NUM_W'({r_eff, 16'd0}))
                 - $signed(NUM_W'(ONE_Q28));
      num_pos  = ~num[NUM_W-1] && (num != '0);
      base     = $signed(ILL_W'(amb_k) + ILL_W'(dir_k) - ILL_W'(prod_ff >>> 14));
      prod_adj = prod_ff[PROD_W-1] ? prod_ff + Q28_BIAS : prod_ff;
      dyn_term = ILL_W'(prod_adj >>> 28);
      for (int i = 0; i < 3; i++) begin
         cl[i] = illum_ff[i][ILL_W-1] ? '0 : illum_ff[i];
      end
      mx01      = (cl[1] > cl[0]) ? cl[1] : cl[0];
      mx        = (cl[2] > mx01) ? cl[2] : mx01;
      nlights   = (cfg.lights > LCNT_W'(DYN_SLOTS)) ? LCNT_W'(DYN_SLOTS) : cfg.lights;
      lcnt_next = lcnt_ff + 1'b1;
   end

   // Shared multiplier; its product is always registered.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_DOTM: begin
            mul_a = MUL_AW'(vec_k);
            mul_b = MUL_BW'(bl_k);
         end
         S_LDOTM: begin
            mul_a = MUL_AW'(vec_k);
            mul_b = MUL_BW'(dv_k);
         end
         S_BASEM: begin
            mul_a = MUL_AW'(dir_k);
            mul_b = MUL_BW'(cw_ff);
         end
         S_LCOLM: begin
            mul_a = MUL_AW'(lc);
            mul_b = MUL_BW'(col_k);
         end
         S_FLATM: begin
            mul_a = MUL_AW'({dir_k, 2'b00});
            mul_b = RECIP5;
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      k_in         = k_ff;
      lcnt_in      = lcnt_ff;
      acc_in       = acc_ff;
      cw_in        = cw_ff;
      mx_in        = mx_ff;
      illum_in     = illum_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               pop     = 1'b1;
               item_in = q_item;
               k_in    = '0;
               unique case (q_item.op)
                  OP_FLAT: state_in = S_FLATM;
                  OP_WRAP: state_in = S_FETCH;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FETCH: begin
            acc_in   = '0;
            state_in = S_DOTM;
         end
         S_DOTM: state_in = S_DOTA;
         S_DOTA: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            if (k_ff == 2'd2) begin
               state_in = S_WRAP;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_DOTM;
            end
         end
         S_WRAP: begin
            k_in = '0;
            if (num_pos) begin
               div_start    = 1'b1;
               div_dividend = DIV_NW'($unsigned(num));
               div_divisor  = DIV_DW'({r_eff, 2'b00});
               state_in     = S_DIVW;
            end else begin
               cw_in    = '0;
               state_in = S_BASEM;
            end
         end
         S_DIVW: begin
            if (div_done) begin
               cw_in    = div_q;
               state_in = S_BASEM;
            end
         end
         S_BASEM: state_in = S_BASEA;
         S_BASEA: begin
            illum_in[k_ff] = base[ILL_W-1] ? '0 : base;
            if (k_ff == 2'd2) begin
               lcnt_in  = '0;
               state_in = (nlights == '0) ? S_MAX : S_LFETCH;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_BASEM;
            end
         end
         S_LFETCH: begin
            acc_in   = '0;
            k_in     = '0;
            state_in = S_LDOTM;
         end
         S_LDOTM: state_in = S_LDOTA;
         S_LDOTA: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            if (k_ff == 2'd2) begin
               state_in = S_LCHK;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_LDOTM;
            end
         end
         S_LCHK: begin
            k_in = '0;
            // The light contributes only when the negated cosine is positive.
            if (acc_ff[ACC_W-1]) begin
               state_in = S_LCOLM;
            end else begin
               lcnt_in  = lcnt_next;
               state_in = (lcnt_next == nlights) ? S_MAX : S_LFETCH;
            end
         end
         S_LCOLM: state_in = S_LCOLA;
         S_LCOLA: begin
            illum_in[k_ff] = ILL_W'(ill_k + dyn_term);
            if (k_ff == 2'd2) begin
               lcnt_in  = lcnt_next;
               state_in = (lcnt_next == nlights) ? S_MAX : S_LFETCH;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_LCOLM;
            end
         end
         S_FLATM: state_in = S_FLATA;
         S_FLATA: begin
            illum_in[k_ff] = ILL_W'(amb_k) + ILL_W'(prod_ff >>> 24);
            if (k_ff == 2'd2) begin
               state_in = S_MAX;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_FLATM;
            end
         end
         S_MAX: begin
            illum_in = cl;
            mx_in    = mx;
            k_in     = '0;
            state_in = (mx > ILL_W'(ONE_Q14)) ? S_NSTART : S_DONE;
         end
         S_NSTART: begin
            div_start    = 1'b1;
            div_dividend = DIV_NW'({illum_ff[k_ff], 14'd0});
            div_divisor  = DIV_DW'(mx_ff);
            state_in     = S_NWAIT;
         end
         S_NWAIT: begin
            if (div_done) begin
               illum_in[k_ff] = ILL_W'(div_q);
               if (k_ff == 2'd2) begin
                  state_in = S_DONE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_NSTART;
               end
            end
         end
         S_DONE: begin
            for (int i = 0; i < 3; i++) begin
               rsp_in[i] = (cl[i] > ILL_W'(ONE_Q14)) ? ONE_Q14 : cl[i][14:0];
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff  <= item_in;
      k_ff     <= k_in;
      lcnt_ff  <= lcnt_in;
      acc_ff   <= acc_in;
      cw_ff    <= cw_in;
      mx_ff    <= mx_in;
      illum_ff <= illum_in;
      rsp_ff   <= rsp_in;
      prod_ff  <= prod_in;
   end
endmodule
`default_nettype wire

[hw/rtl/vertex_color_lighting_top.sv]
`default_nettype none
// Colored per-vertex lighting with half-Lambert wrap. A request is taken on
// a rising edge with start high and busy low; loads of the bone light table,
// the dynamic light vectors and the dynamic light colors produce nothing,
// while a shade request produces one RGB result that is shown on rsp_red,
// rsp_green and rsp_blue for exactly one cycle with rsp_valid high. The
// receiver cannot stall: a result must be captured in that cycle. A front
// stage classifies requests and drops loads to bones or slots that do not
// exist; a four-entry queue feeds the back end, so busy rises only when the
// queue and the front stage are both full. The back end works one request at
// a time: a load is written to its table as it is popped from the queue, a
// vertex is shaded on the flat or the wrap path, the wrap path visits each
// active dynamic light, and all channels are renormalized when the brightest
// channel exceeds one. The back end's pace is set by the single shared
// multiplier, which handles every product with a registered result, and by
// the shared one-bit-per-cycle divider used for the wrap term and the renormalization.
// Configuration registers may be written only while no shade is in flight.
module vertex_color_lighting_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [6:0]         req_bone,
   input  logic [2:0]         req_light_slot,
   input  logic               req_flat_shade,
   input  logic signed [15:0] req_vec_x,
   input  logic signed [15:0] req_vec_y,
   input  logic signed [15:0] req_vec_z,
   output logic               rsp_valid,
   output logic [14:0]        rsp_red,
   output logic [14:0]        rsp_green,
   output logic [14:0]        rsp_blue,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import vcl_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_status;
   item_type     push_item, pop_item;
   logic         push, pop;

   // Register file: the wrap factor is kept raw and clamped where it is used.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_type'(csr_index))
            CSR_AMB_R:  cfg_in.ambient[0] = csr_data;
            CSR_AMB_G:  cfg_in.ambient[1] = csr_data;
            CSR_AMB_B:  cfg_in.ambient[2] = csr_data;
            CSR_DIR_R:  cfg_in.direct[0]  = csr_data;
            CSR_DIR_G:  cfg_in.direct[1]  = csr_data;
            CSR_DIR_B:  cfg_in.direct[2]  = csr_data;
            CSR_WRAP:   cfg_in.wrap       = csr_data;
            CSR_LIGHTS: cfg_in.lights     = csr_data[3:0];
            default:    cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ambient <= {16'd8192, 16'd8192, 16'd8192};
         cfg_ff.direct  <= '0;
         cfg_ff.wrap    <= 16'd24576;
         cfg_ff.lights  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vcl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_bone       (req_bone),
      .req_light_slot (req_light_slot),
      .req_flat_shade (req_flat_shade),
      .req_vec_x      (req_vec_x),
      .req_vec_y      (req_vec_y),
      .req_vec_z      (req_vec_z),
      .q_status       (q_status),
      .push           (push),
      .push_item      (push_item)
   );

   vcl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   vcl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_item    (pop_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );
endmodule
`default_nettype wire

[hw/rtl/vcl_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module vcl_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [14:0] rsp_red,
   input logic [14:0] rsp_green,
   input logic [14:0] rsp_blue
);
   logic rsp_in_range;

   assign rsp_in_range = (rsp_red <= 15'd16384) && (rsp_green <= 15'd16384)
                         && (rsp_blue <= 15'd16384);

   `VCL_ASSERT_RST(a_no_rsp_after_reset, reset |=> !rsp_valid, "result right after reset")
   `VCL_ASSERT_RST(a_ready_after_reset, reset |=> !busy, "busy right after reset")
   `VCL_ASSERT(a_rsp_single_cycle, rsp_valid |=> !rsp_valid, "results in adjacent cycles")
   `VCL_ASSERT(a_rsp_range, rsp_valid |-> rsp_in_range, "result above one")
endmodule

bind vertex_color_lighting_top vcl_checker u_checker (.*);
`default_nettype wire
